[hdl/multi_joint_servo_slew_limiter_macros.svh]
// Assertion macros used by the servo slew limiter checker.
`ifndef MULTI_JOINT_SERVO_SLEW_LIMITER_MACROS_SVH
`define MULTI_JOINT_SERVO_SLEW_LIMITER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define MSL_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define MSL_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/msl_pkg.sv]
// Shared types, constants and joint tables for the servo slew limiter.
package msl_pkg;

    localparam int NUM_JOINTS = 6;
    localparam int IO_JOINTS  = 6;
    localparam int MAX_JOINTS = 16;
    localparam int LANES      = (NUM_JOINTS > MAX_JOINTS) ? MAX_JOINTS : NUM_JOINTS;

    localparam int ANG_W     = 15;
    localparam int TGT_W     = 17;
    localparam int PULSE_W   = 12;
    localparam int STEP_W    = 15;
    localparam int WIN_W     = 10;
    localparam int TICK_W    = 10;
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 2;

    localparam int DIV9_MUL_W = 13;
    localparam int DIV9_SHIFT = 16;
    localparam int SUM_W      = ANG_W + 1;
    localparam int PROD_W     = SUM_W + DIV9_MUL_W;
    localparam int QUOT_W     = PROD_W - DIV9_SHIFT;

    typedef logic [ANG_W-1:0]          t_angle;
    typedef logic signed [TGT_W-1:0]   t_target;
    typedef logic [PULSE_W-1:0]        t_pulse;
    typedef logic [STEP_W-1:0]         t_step;
    typedef logic [WIN_W-1:0]          t_window;
    typedef logic [TICK_W-1:0]         t_tick;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_STEP      = 2'd0,
        CFG_ARRIVE_WINDOW = 2'd1,
        CFG_TICK_LIMIT    = 2'd2
    } t_cfg_idx;

    typedef enum logic {
        CMD_SET_TARGET = 1'b0,
        CMD_TICK       = 1'b1
    } t_cmd;

    typedef struct packed {
        logic set;
        logic step;
    } t_lane_ctl;

    localparam t_step   MAX_STEP_RST      = 15'd100;
    localparam t_window ARRIVE_WINDOW_RST = 10'd5;
    localparam t_tick   TICK_LIMIT_RST    = 10'd220;

    localparam t_pulse PULSE_BASE = 12'd500;
    localparam logic [SUM_W-1:0] ROUND_OFS = 16'd4;
    localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 13'd7282;

    localparam t_angle LIM_LO [MAX_JOINTS] = '{
        15'd0, 15'd1500, 15'd0, 15'd0, 15'd0, 15'd1000,
        15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0};
    localparam t_angle LIM_HI [MAX_JOINTS] = '{
        15'd18000, 15'd16500, 15'd18000, 15'd18000, 15'd18000, 15'd11000,
        15'd18000, 15'd18000, 15'd18000, 15'd18000, 15'd18000, 15'd18000,
        15'd18000, 15'd18000, 15'd18000, 15'd18000};
    localparam t_angle HOME_POS [MAX_JOINTS] = '{
        15'd9000, 15'd4500, 15'd18000, 15'd18000, 15'd9000, 15'd1000,
        15'd9000, 15'd9000, 15'd9000, 15'd9000, 15'd9000, 15'd9000,
        15'd9000, 15'd9000, 15'd9000, 15'd9000};

endpackage

[hdl/msl_in_if.sv]
// Command channel: valid, ready and the command with six requested angles.
interface msl_in_if;
    import msl_pkg::*;

    logic    valid;
    logic    ready;
    logic    command;
    t_target target_base;
    t_target target_shoulder;
    t_target target_elbow;
    t_target target_wrist_pitch;
    t_target target_wrist_roll;
    t_target target_grip;

    modport source (
        output valid, command, target_base, target_shoulder, target_elbow,
               target_wrist_pitch, target_wrist_roll, target_grip,
        input  ready
    );
    modport sink (
        input  valid, command, target_base, target_shoulder, target_elbow,
               target_wrist_pitch, target_wrist_roll, target_grip,
        output ready
    );
endinterface

[hdl/msl_out_if.sv]
// Result channel: valid, ready, six pulse widths and the status flags.
interface msl_out_if;
    import msl_pkg::*;

    logic   valid;
    logic   ready;
    t_pulse pulse_base;
    t_pulse pulse_shoulder;
    t_pulse pulse_elbow;
    t_pulse pulse_wrist_pitch;
    t_pulse pulse_wrist_roll;
    t_pulse pulse_grip;
    logic   arrived;
    logic   timed_out;

    modport source (
        output valid, pulse_base, pulse_shoulder, pulse_elbow, pulse_wrist_pitch,
               pulse_wrist_roll, pulse_grip, arrived, timed_out,
        input  ready
    );
    modport sink (
        input  valid, pulse_base, pulse_shoulder, pulse_elbow, pulse_wrist_pitch,
               pulse_wrist_roll, pulse_grip, arrived, timed_out,
        output ready
    );
endinterface

[hdl/msl_lane.sv]
// One joint lane: target clamp, slew-limited position update and pulse width.
module msl_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  msl_pkg::t_lane_ctl  i_ctl,
    input  msl_pkg::t_target    i_target,
    input  msl_pkg::t_angle     i_lim_lo,
    input  msl_pkg::t_angle     i_lim_hi,
    input  msl_pkg::t_angle     i_home,
    input  msl_pkg::t_step      i_max_step,
    input  msl_pkg::t_window    i_window,
    output logic                o_in_window,
    output msl_pkg::t_pulse     o_pulse
);
    import msl_pkg::*;

    t_angle r_pos;
    t_angle r_tgt;
    t_angle n_pos;
    t_angle n_tgt;

    logic signed [ANG_W:0]  w_diff;
    logic signed [ANG_W:0]  w_neg;
    t_angle                 w_mag;
    t_angle                 w_move;
    t_target                w_lo;
    t_target                w_hi;
    logic [SUM_W-1:0]       w_sum;
    logic [PROD_W-1:0]      w_prod;
    logic [QUOT_W-1:0]      w_quot;

    assign w_diff = $signed({1'b0, r_tgt}) - $signed({1'b0, r_pos});
    assign w_neg  = -w_diff;
    assign w_mag  = w_diff[ANG_W] ? w_neg[ANG_W-1:0] : w_diff[ANG_W-1:0];
    assign o_in_window = (w_mag <= ANG_W'(i_window));
    assign w_move = (w_mag < i_max_step) ? w_mag : i_max_step;

    assign w_lo = $signed({2'b00, i_lim_lo});
    assign w_hi = $signed({2'b00, i_lim_hi});

    always_comb begin
        if (i_target < w_lo) begin
            n_tgt = i_lim_lo;
        end else if (i_target > w_hi) begin
            n_tgt = i_lim_hi;
        end else begin
            n_tgt = i_target[ANG_W-1:0];
        end
    end

    always_comb begin
        if (o_in_window) begin
            n_pos = r_tgt;
        end else if (w_diff[ANG_W]) begin
            n_pos = r_pos - w_move;
        end else begin
            n_pos = r_pos + w_move;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= i_home;
            r_tgt <= i_home;
        end else begin
            if (i_ctl.set) begin
                r_tgt <= n_tgt;
            end
            if (i_ctl.step) begin
                r_pos <= n_pos;
            end
        end
    end

    // Rounded division by nine through a fixed-point reciprocal.
    assign w_sum   = {1'b0, r_pos} + ROUND_OFS;
    assign w_prod  = PROD_W'(w_sum) * PROD_W'(DIV9_MUL);
    assign w_quot  = w_prod[PROD_W-1:DIV9_SHIFT];
    assign o_pulse = PULSE_BASE + PULSE_W'(w_quot);

endmodule

[hdl/msl_ctrl.sv]
// Merging and control: tick count, arrival, timeout and the two-stage handshake.
module msl_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  msl_pkg::t_cmd            i_cmd,
    input  msl_pkg::t_tick           i_tick_limit,
    input  logic [msl_pkg::LANES-1:0] i_in_window,
    input  logic                     i_out_ready,
    output logic                     o_in_ready,
    output msl_pkg::t_lane_ctl       o_lane_ctl,
    output logic                     o_load,
    output logic                     o_out_valid,
    output logic                     o_arrived,
    output logic                     o_timed_out
);
    import msl_pkg::*;

    t_tick r_tick;
    logic  r_arrived_flag;
    logic  r_s1_valid;
    logic  r_s1_arr;
    logic  r_s1_tout;
    logic  r_out_valid;
    logic  r_out_arr;
    logic  r_out_tout;

    logic  w_adv;
    logic  w_acc;
    logic  w_frozen;
    logic  w_all_in;
    logic  w_is_tick;

    assign w_adv     = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_s1_valid || w_adv;
    assign w_acc     = i_in_valid && o_in_ready;
    assign w_is_tick = (i_cmd == CMD_TICK);
    assign w_frozen  = !r_arrived_flag && (r_tick >= i_tick_limit);
    assign w_all_in  = &i_in_window;

    assign o_lane_ctl.set  = w_acc && !w_is_tick;
    assign o_lane_ctl.step = w_acc && w_is_tick && !w_frozen;
    assign o_load          = r_s1_valid && w_adv;
    assign o_out_valid     = r_out_valid;
    assign o_arrived       = r_out_arr;
    assign o_timed_out     = r_out_tout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick         <= '0;
            r_arrived_flag <= 1'b1;
            r_s1_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_lane_ctl.set) begin
                r_tick         <= '0;
                r_arrived_flag <= 1'b0;
            end else if (o_lane_ctl.step) begin
                r_arrived_flag <= w_all_in;
                if (r_tick != '1) begin
                    r_tick <= r_tick + 1'b1;
                end
            end

            if (w_acc) begin
                r_s1_valid <= 1'b1;
            end else if (w_adv) begin
                r_s1_valid <= 1'b0;
            end

            if (o_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_s1_arr  <= o_lane_ctl.step && w_all_in;
            r_s1_tout <= w_is_tick && w_frozen;
        end
        if (o_load) begin
            r_out_arr  <= r_s1_arr;
            r_out_tout <= r_s1_tout;
        end
    end

endmodule

[hdl/multi_joint_servo_slew_limiter.sv]
// Top level of the six-joint servo slew limiter.
//
// Commands arrive on i_in, a valid/ready channel; a transfer takes place at a
// rising edge with valid and ready both high. Command set-target clamps the six
// requested angles to their joint limits, stores them and restarts the tick
// count. Command tick moves all joints toward their targets in parallel lanes.
// Every command yields one result on o_out: six pulse widths from the updated
// positions plus the arrived and timed_out flags.
// A command's result passes through the lane state stage and then the output
// register before it appears on o_out. One command is taken every cycle while
// o_out does not stall; the rate is set by the single lane update per cycle
// followed by the pulse stage with its multiplier. When the receiver stalls,
// the result holds in the output register and one more command is absorbed in
// the lane state stage before i_in.ready drops. Synchronous reset returns
// joints to their home positions, sets the arrived flag, clears the tick count
// and loads the register defaults. The user must make configuration writes on
// i_cfg_we/i_cfg_idx/i_cfg_wdata only while idle; the block does not enforce it.
module multi_joint_servo_slew_limiter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    msl_in_if.sink                        i_in,
    msl_out_if.source                     o_out,
    input  logic                          i_cfg_we,
    input  logic [msl_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [msl_pkg::CFG_W-1:0]     i_cfg_wdata
);
    import msl_pkg::*;

    t_step     r_max_step;
    t_window   r_window;
    t_tick     r_tick_limit;
    t_pulse    r_pulse [IO_JOINTS];

    t_target   w_tgt   [IO_JOINTS];
    t_pulse    w_pulse [LANES];
    logic [LANES-1:0] w_in_window;
    t_lane_ctl w_ctl;
    logic      w_load;
    logic      w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_step   <= MAX_STEP_RST;
            r_window     <= ARRIVE_WINDOW_RST;
            r_tick_limit <= TICK_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_MAX_STEP:      r_max_step   <= i_cfg_wdata[STEP_W-1:0];
                CFG_ARRIVE_WINDOW: r_window     <= i_cfg_wdata[WIN_W-1:0];
                CFG_TICK_LIMIT:    r_tick_limit <= i_cfg_wdata[TICK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    assign w_tgt[0] = i_in.target_base;
    assign w_tgt[1] = i_in.target_shoulder;
    assign w_tgt[2] = i_in.target_elbow;
    assign w_tgt[3] = i_in.target_wrist_pitch;
    assign w_tgt[4] = i_in.target_wrist_roll;
    assign w_tgt[5] = i_in.target_grip;

    for (genvar j = 0; j < LANES; j++) begin : g_lane
        t_lane_ctl w_lane_ctl;
        t_target   w_lane_tgt;

        if (j < IO_JOINTS) begin : g_io
            assign w_lane_ctl = w_ctl;
            assign w_lane_tgt = w_tgt[j];
        end else begin : g_extra
            assign w_lane_ctl = '{set: 1'b0, step: w_ctl.step};
            assign w_lane_tgt = '0;
        end

        msl_lane u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_lane_ctl),
            .i_target    (w_lane_tgt),
            .i_lim_lo    (LIM_LO[j]),
            .i_lim_hi    (LIM_HI[j]),
            .i_home      (HOME_POS[j]),
            .i_max_step  (r_max_step),
            .i_window    (r_window),
            .o_in_window (w_in_window[j]),
            .o_pulse     (w_pulse[j])
        );
    end

    msl_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in.valid),
        .i_cmd        (t_cmd'(i_in.command)),
        .i_tick_limit (r_tick_limit),
        .i_in_window  (w_in_window),
        .i_out_ready  (o_out.ready),
        .o_in_ready   (w_in_ready),
        .o_lane_ctl   (w_ctl),
        .o_load       (w_load),
        .o_out_valid  (o_out.valid),
        .o_arrived    (o_out.arrived),
        .o_timed_out  (o_out.timed_out)
    );

    assign i_in.ready = w_in_ready;

    for (genvar k = 0; k < IO_JOINTS; k++) begin : g_pulse
        if (k < LANES) begin : g_live
            always_ff @(posedge i_clk) begin
                if (w_load) begin
                    r_pulse[k] <= w_pulse[k];
                end
            end
        end else begin : g_idle
            always_ff @(posedge i_clk) begin
                if (w_load) begin
                    r_pulse[k] <= PULSE_BASE;
                end
            end
        end
    end

    assign o_out.pulse_base        = r_pulse[0];
    assign o_out.pulse_shoulder    = r_pulse[1];
    assign o_out.pulse_elbow       = r_pulse[2];
    assign o_out.pulse_wrist_pitch = r_pulse[3];
    assign o_out.pulse_wrist_roll  = r_pulse[4];
    assign o_out.pulse_grip        = r_pulse[5];

endmodule

[hdl/msl_chk.sv]
// Port-level checker for the servo slew limiter and its bind statement.
`include "multi_joint_servo_slew_limiter_macros.svh"

module msl_chk (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_out_valid,
    input logic                  i_out_ready,
    input logic                  i_arrived,
    input logic                  i_timed_out,
    input msl_pkg::t_pulse       i_pulse_base,
    input logic [73:0]           i_out_data
);
    import msl_pkg::*;

    `MSL_ASSERT_NXT(a_out_valid_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid, "Result valid dropped while stalled.")
    `MSL_ASSERT_NXT(a_out_data_holds, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_data), "Result changed while stalled.")
    `MSL_ASSERT_IMP(a_flags_exclusive, i_clk, i_rst_n, i_out_valid, !(i_arrived && i_timed_out), "Arrived and timed_out both set.")
    `MSL_ASSERT_IMP(a_pulse_range, i_clk, i_rst_n, i_out_valid, (i_pulse_base >= PULSE_BASE) && (i_pulse_base <= 12'd2500), "Base pulse out of range.")

endmodule

bind multi_joint_servo_slew_limiter msl_chk u_msl_chk (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_arrived    (o_out.arrived),
    .i_timed_out  (o_out.timed_out),
    .i_pulse_base (o_out.pulse_base),
    .i_out_data   ({o_out.pulse_base, o_out.pulse_shoulder, o_out.pulse_elbow,
                    o_out.pulse_wrist_pitch, o_out.pulse_wrist_roll, o_out.pulse_grip,
                    o_out.arrived, o_out.timed_out})
);
